/* rtl/tpc_pkg.sv */
// Shared types, constants and reciprocal divisors for the triangle projection and cull unit.
package tpc_pkg;

    // Pipeline depth: five stages inside each vertex lane plus the merge/output stage.
    localparam int unsigned STAGES = 6;

    // Projection constants.
    localparam logic signed [17:0] LON_BIAS = 18'sd18000;
    localparam logic signed [15:0] LAT_BIAS = 16'sd9000;

    localparam longint unsigned DIV_X = 64'd36000;
    localparam longint unsigned DIV_Y = 64'd18000;
    localparam longint unsigned DIV_Z = 64'd100;

    // Exact division by a constant: q = (n * M) >> S for every n below 2**N,
    // with S = N + ceil(log2(d)) and M = ceil(2**S / d).
    localparam int unsigned X_MAG_W = 29;
    localparam int unsigned Y_MAG_W = 27;
    localparam int unsigned Z_MAG_W = 30;

    localparam int unsigned X_SHIFT = X_MAG_W + 16;
    localparam int unsigned Y_SHIFT = Y_MAG_W + 15;
    localparam int unsigned Z_SHIFT = Z_MAG_W + 7;

    localparam int unsigned X_RECIP_W = X_MAG_W + 1;
    localparam int unsigned Y_RECIP_W = Y_MAG_W + 1;
    localparam int unsigned Z_RECIP_W = Z_MAG_W + 1;

    localparam logic [X_RECIP_W-1:0] X_RECIP =
        X_RECIP_W'(((64'd1 << X_SHIFT) + DIV_X - 64'd1) / DIV_X);
    localparam logic [Y_RECIP_W-1:0] Y_RECIP =
        Y_RECIP_W'(((64'd1 << Y_SHIFT) + DIV_Y - 64'd1) / DIV_Y);
    localparam logic [Z_RECIP_W-1:0] Z_RECIP =
        Z_RECIP_W'(((64'd1 << Z_SHIFT) + DIV_Z - 64'd1) / DIV_Z);

    // Register map, word index into the configuration space.
    typedef enum logic [2:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_MAP_WIDTH    = 3'd2,
        REG_MAP_HEIGHT   = 3'd3,
        REG_CENTER_X     = 3'd4,
        REG_CENTER_Y     = 3'd5,
        REG_ZOOM_PERCENT = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic        [11:0] origin_x;
        logic        [11:0] origin_y;
        logic        [11:0] map_width;
        logic        [11:0] map_height;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic        [13:0] zoom_percent;
    } cfg_t;

    // One load enable per pipeline stage, bit 0 is the first stage.
    typedef logic [STAGES-1:0] stage_en_t;

    typedef struct packed {
        logic left;
        logic right;
        logic top;
    } edge_flags_t;

endpackage

/* rtl/triangle_projection_cull_unit.sv */
// Top level of the triangle projection and cull unit: stream ports, register file, pipeline control.
//
// Each transfer on the slave stream carries one triangle as three longitude/latitude
// vertices in hundredths of a degree. Three identical vertex lanes map the vertices
// side by side into the map rectangle (x from longitude over a 360 degree span, y from
// latitude over a 180 degree span, both scaled by the rectangle size and offset by its
// origin), zoom each point about the programmed center by zoom_percent / 100, and clamp
// y to the rectangle's bottom edge. Every division truncates toward zero and every
// coordinate wraps to 16 bits two's complement. A merge stage then clears visible when
// all three vertices lie left of, right of, or above the rectangle. The unit accepts
// one triangle per clock cycle while the output is not stalled and returns one result
// per triangle in order, registered through these stages: two constant-reciprocal multiply
// stages per lane for the map division and the zoom division, one stage each for the
// scaling multiply, the zoom multiply and the final add/clamp/edge tests, and one output
// register in the merge stage. Each stage moves as soon as the stage after it is empty or
// moving, so bubbles close up and a new triangle is still taken while a finished result
// waits for m_tready, as long as an earlier stage is empty. Registers sit on the APB
// port at byte addresses 0x00 origin_x, 0x04 origin_y, 0x08 map_width, 0x0C map_height,
// 0x10 center_x, 0x14 center_y and 0x18 zoom_percent; they are read back as written
// (centers sign-extended) and should only be changed while no triangle is in flight.
module triangle_projection_cull_unit (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Triangle input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // lon_a[15:0], lat_a[30:16], lon_b[46:31], lat_b[61:47],
                                   // lon_c[77:62], lat_c[92:78], zero [95:93]
    // Projected triangle output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // screen_xa[15:0], screen_ya[31:16], screen_xb[47:32],
                                   // screen_yb[63:48], screen_xc[79:64], screen_yc[95:80]
    output logic        m_tuser    // visible[0]
);
    import tpc_pkg::*;

    // Configuration registers.
    cfg_t       cfg_reg;
    reg_index_t wr_index;
    reg_index_t rd_index;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign wr_index  = reg_index_t'(paddr[4:2]);
    assign rd_index  = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= 12'd0;
            cfg_reg.origin_y     <= 12'd0;
            cfg_reg.map_width    <= 12'd640;
            cfg_reg.map_height   <= 12'd320;
            cfg_reg.center_x     <= 16'sd320;
            cfg_reg.center_y     <= 16'sd160;
            cfg_reg.zoom_percent <= 14'd100;
        end
        else if (cfg_write)
        begin
            unique case (wr_index)
                REG_ORIGIN_X:     cfg_reg.origin_x     <= pwdata[11:0];
                REG_ORIGIN_Y:     cfg_reg.origin_y     <= pwdata[11:0];
                REG_MAP_WIDTH:    cfg_reg.map_width    <= pwdata[11:0];
                REG_MAP_HEIGHT:   cfg_reg.map_height   <= pwdata[11:0];
                REG_CENTER_X:     cfg_reg.center_x     <= $signed(pwdata[15:0]);
                REG_CENTER_Y:     cfg_reg.center_y     <= $signed(pwdata[15:0]);
                REG_ZOOM_PERCENT: cfg_reg.zoom_percent <= pwdata[13:0];
                default:          ;
            endcase
        end
    end

    // Read data is a plain decode of the address; unused addresses read as zero.
    always_comb
    begin
        unique case (rd_index)
            REG_ORIGIN_X:     prdata = {20'd0, cfg_reg.origin_x};
            REG_ORIGIN_Y:     prdata = {20'd0, cfg_reg.origin_y};
            REG_MAP_WIDTH:    prdata = {20'd0, cfg_reg.map_width};
            REG_MAP_HEIGHT:   prdata = {20'd0, cfg_reg.map_height};
            REG_CENTER_X:     prdata = {{16{cfg_reg.center_x[15]}}, cfg_reg.center_x};
            REG_CENTER_Y:     prdata = {{16{cfg_reg.center_y[15]}}, cfg_reg.center_y};
            REG_ZOOM_PERCENT: prdata = {18'd0, cfg_reg.zoom_percent};
            default:          prdata = 32'd0;
        endcase
    end

    // Pipeline control. A stage may load when it is empty or when the stage after it
    // moves on in the same cycle; the last stage moves when the output transfer completes.
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    stage_en_t         stage_en;

    always_comb
    begin
        stage_en[STAGES-1] = ~valid_reg[STAGES-1] | m_tready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = ~valid_reg[k] | stage_en[k+1];
        end
        valid_next[0] = stage_en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[STAGES-1];

    // Vertex lanes.
    logic signed [2:0][15:0] lon;
    logic signed [2:0][14:0] lat;
    logic signed [2:0][15:0] lane_sx;
    logic signed [2:0][15:0] lane_sy;
    edge_flags_t [2:0]       lane_flags;

    assign lon[0] = s_tdata[15:0];
    assign lat[0] = s_tdata[30:16];
    assign lon[1] = s_tdata[46:31];
    assign lat[1] = s_tdata[61:47];
    assign lon[2] = s_tdata[77:62];
    assign lat[2] = s_tdata[92:78];

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        tpc_vertex_lane u_lane (
            .clk   (clk),
            .en    (stage_en),
            .cfg   (cfg_reg),
            .lon   (lon[g]),
            .lat   (lat[g]),
            .sx    (lane_sx[g]),
            .sy    (lane_sy[g]),
            .flags (lane_flags[g])
        );
    end

    tpc_merge u_merge (
        .clk     (clk),
        .en      (stage_en[STAGES-1]),
        .sx      (lane_sx),
        .sy      (lane_sy),
        .flags   (lane_flags),
        .tdata   (m_tdata),
        .visible (m_tuser)
    );

endmodule

/* rtl/tpc_vertex_lane.sv */
// One vertex lane: equirectangular mapping, zoom about the center, bottom clamp and edge tests.
module tpc_vertex_lane (
    input  logic                      clk,
    input  tpc_pkg::stage_en_t        en,
    input  tpc_pkg::cfg_t             cfg,
    input  logic signed [15:0]        lon,
    input  logic signed [14:0]        lat,
    output logic signed [15:0]        sx,
    output logic signed [15:0]        sy,
    output tpc_pkg::edge_flags_t      flags
);
    import tpc_pkg::*;

    // Stage 1: scaled offsets from the map corner.
    logic signed [17:0] lon_ofs;
    logic signed [15:0] lat_ofs;
    logic signed [30:0] prod_x;
    logic signed [28:0] prod_y;
    logic        [29:0] nx_reg;
    logic        [28:0] ny_reg;

    assign lon_ofs = {{2{lon[15]}}, lon} + LON_BIAS;
    assign lat_ofs = LAT_BIAS - {lat[14], lat};
    assign prod_x  = lon_ofs * $signed({1'b0, cfg.map_width});
    assign prod_y  = lat_ofs * $signed({1'b0, cfg.map_height});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            nx_reg <= prod_x[29:0];
            ny_reg <= prod_y[28:0];
        end
    end

    // Stage 2: divide by the map span, truncating toward zero via sign and magnitude.
    logic [29:0]                   nx_neg;
    logic [28:0]                   ny_neg;
    logic [X_MAG_W-1:0]            mag_x;
    logic [Y_MAG_W-1:0]            mag_y;
    logic [X_MAG_W+X_RECIP_W-1:0]  px;
    logic [Y_MAG_W+Y_RECIP_W-1:0]  py;
    logic [15:0]                   qx_reg;
    logic [15:0]                   qy_reg;
    logic                          negx_reg;
    logic                          negy_reg;

    assign nx_neg = -nx_reg;
    assign ny_neg = -ny_reg;
    assign mag_x  = nx_reg[29] ? nx_neg[X_MAG_W-1:0] : nx_reg[X_MAG_W-1:0];
    assign mag_y  = ny_reg[28] ? ny_neg[Y_MAG_W-1:0] : ny_reg[Y_MAG_W-1:0];
    assign px     = (X_MAG_W+X_RECIP_W)'(mag_x) * (X_MAG_W+X_RECIP_W)'(X_RECIP);
    assign py     = (Y_MAG_W+Y_RECIP_W)'(mag_y) * (Y_MAG_W+Y_RECIP_W)'(Y_RECIP);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            qx_reg   <= 16'(px >> X_SHIFT);
            qy_reg   <= 16'(py >> Y_SHIFT);
            negx_reg <= nx_reg[29];
            negy_reg <= ny_reg[28];
        end
    end

    // Stage 3: base screen point, then its distance from the center times the zoom.
    logic        [15:0] bx;
    logic        [15:0] by;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [31:0] zx;
    logic signed [31:0] zy;
    logic        [30:0] zx_reg;
    logic        [30:0] zy_reg;

    assign bx = {4'b0, cfg.origin_x} + (negx_reg ? -qx_reg : qx_reg);
    assign by = {4'b0, cfg.origin_y} + (negy_reg ? -qy_reg : qy_reg);
    assign dx = $signed({bx[15], bx}) - $signed({cfg.center_x[15], cfg.center_x});
    assign dy = $signed({by[15], by}) - $signed({cfg.center_y[15], cfg.center_y});
    assign zx = dx * $signed({1'b0, cfg.zoom_percent});
    assign zy = dy * $signed({1'b0, cfg.zoom_percent});

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            zx_reg <= zx[30:0];
            zy_reg <= zy[30:0];
        end
    end

    // Stage 4: divide the zoomed distance by one hundred.
    logic [30:0]                   zx_neg;
    logic [30:0]                   zy_neg;
    logic [Z_MAG_W-1:0]            mag_zx;
    logic [Z_MAG_W-1:0]            mag_zy;
    logic [Z_MAG_W+Z_RECIP_W-1:0]  pzx;
    logic [Z_MAG_W+Z_RECIP_W-1:0]  pzy;
    logic [15:0]                   qzx_reg;
    logic [15:0]                   qzy_reg;
    logic                          negzx_reg;
    logic                          negzy_reg;

    assign zx_neg = -zx_reg;
    assign zy_neg = -zy_reg;
    assign mag_zx = zx_reg[30] ? zx_neg[Z_MAG_W-1:0] : zx_reg[Z_MAG_W-1:0];
    assign mag_zy = zy_reg[30] ? zy_neg[Z_MAG_W-1:0] : zy_reg[Z_MAG_W-1:0];
    assign pzx    = (Z_MAG_W+Z_RECIP_W)'(mag_zx) * (Z_MAG_W+Z_RECIP_W)'(Z_RECIP);
    assign pzy    = (Z_MAG_W+Z_RECIP_W)'(mag_zy) * (Z_MAG_W+Z_RECIP_W)'(Z_RECIP);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            qzx_reg   <= 16'(pzx >> Z_SHIFT);
            qzy_reg   <= 16'(pzy >> Z_SHIFT);
            negzx_reg <= zx_reg[30];
            negzy_reg <= zy_reg[30];
        end
    end

    // Stage 5: add back the center, clamp to the bottom edge and test the edges.
    logic        [15:0] fx;
    logic        [15:0] fy;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] cy;
    logic signed [15:0] sx_reg;
    logic signed [15:0] sy_reg;
    edge_flags_t        flags_reg;

    assign x0 = $signed({4'b0, cfg.origin_x});
    assign y0 = $signed({4'b0, cfg.origin_y});
    assign x1 = $signed({4'b0, cfg.origin_x} + {4'b0, cfg.map_width} - 16'd1);
    assign y1 = $signed({4'b0, cfg.origin_y} + {4'b0, cfg.map_height} - 16'd1);
    assign fx = cfg.center_x + (negzx_reg ? -qzx_reg : qzx_reg);
    assign fy = cfg.center_y + (negzy_reg ? -qzy_reg : qzy_reg);
    assign cy = ($signed(fy) > y1) ? y1 : $signed(fy);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            sx_reg          <= $signed(fx);
            sy_reg          <= cy;
            flags_reg.left  <= $signed(fx) < x0;
            flags_reg.right <= $signed(fx) > x1;
            flags_reg.top   <= cy < y0;
        end
    end

    assign sx    = sx_reg;
    assign sy    = sy_reg;
    assign flags = flags_reg;

endmodule

/* rtl/tpc_merge.sv */
// Merge stage: combines the three lanes' edge tests into the visible flag and holds the result.
module tpc_merge (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [2:0][15:0]       sx,
    input  logic signed [2:0][15:0]       sy,
    input  tpc_pkg::edge_flags_t [2:0]    flags,
    output logic [95:0]                   tdata,
    output logic                          visible
);
    import tpc_pkg::*;

    logic [95:0] tdata_reg;
    logic        visible_reg;
    logic        all_left;
    logic        all_right;
    logic        all_top;

    assign all_left  = flags[0].left  & flags[1].left  & flags[2].left;
    assign all_right = flags[0].right & flags[1].right & flags[2].right;
    assign all_top   = flags[0].top   & flags[1].top   & flags[2].top;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tdata_reg   <= {sy[2], sx[2], sy[1], sx[1], sy[0], sx[0]};
            visible_reg <= ~(all_left | all_right | all_top);
        end
    end

    assign tdata   = tdata_reg;
    assign visible = visible_reg;

endmodule
